/* sv/sn2_pkg.sv */
// Shared types, constants and gradient lookup for the 2D simplex noise grid block.
`default_nettype none
package sn2_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int PERM_BITS  = 8;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        REG_OFFSET_X  = 3'd0,
        REG_OFFSET_Y  = 3'd1,
        REG_SCALE_X   = 3'd2,
        REG_SCALE_Y   = 3'd3,
        REG_ORIGIN_X  = 3'd4,
        REG_ORIGIN_Y  = 3'd5,
        REG_AMPLITUDE = 3'd6,
        REG_OVERWRITE = 3'd7
    } reg_idx_t;

    localparam logic signed [19:0] F2_Q20   = 20'sd383805;
    localparam logic signed [18:0] G2_Q20   = 19'sd221590;
    localparam logic signed [47:0] G2_Q16   = 48'sd13849;
    localparam logic signed [47:0] ONE_Q16  = 48'sd65536;
    localparam logic signed [34:0] HALF_Q32 = 35'sd2147483648;
    localparam logic signed [7:0]  GAIN_70  = 8'sd70;

    typedef struct packed {
        logic x_pos;
        logic x_neg;
        logic y_pos;
        logic y_neg;
    } grad_t;

    // g mod 12 via reciprocal multiply (exact for 8-bit g), then gradient signs
    function automatic grad_t grad_of(input logic [7:0] g);
        logic [15:0] prod;
        logic [4:0]  q;
        logic [7:0]  m;
        grad_t       r;
        prod = {8'b0, g} * 16'd171;
        q    = prod[15:11];
        m    = g - 8'({3'b0, q} * 8'd12);
        r    = '0;
        if (!m[3]) begin
            r.x_pos = !m[0];
            r.x_neg = m[0];
            if (!m[2]) begin
                r.y_pos = !m[1];
                r.y_neg = m[1];
            end
        end else begin
            r.y_pos = !m[0];
            r.y_neg = m[0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* sv/simplex_noise_2d_grid.sv */
// Top level: pipelined 2D simplex noise over a grid with APB configuration.
// Throughput: one item per cycle; the whole pipeline holds while m_tready is low
// and a result waits in the output register.
// Five table reads per sample use five 256x8 copies of the permutation table.
// Reset clears valid bits and configuration; the permutation table is not reset.
`default_nettype none
module simplex_noise_2d_grid #(
    parameter int INDEX_BITS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // perm_index, perm_value, grid_x, grid_y, prior_value
    input  wire logic [79:0] s_tdata,
    // op
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // noise_value
    output logic [31:0]      m_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    localparam int IB  = (INDEX_BITS < 16) ? INDEX_BITS : 16;
    localparam int NS  = 21;
    localparam int RD1 = 7;
    localparam int RD2 = 11;

    // configuration
    logic signed [39:0] offset_reg [2];
    logic signed [31:0] scale_reg  [2];
    logic        [31:0] origin_reg [2];
    logic signed [31:0] amplitude_reg;
    logic               overwrite_reg;

    logic en;
    logic m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic [31:0] res_next;

    // carried fields
    logic                v_reg     [1:NS];
    logic                op_reg    [1:NS];
    logic signed [31:0]  prior_reg [1:NS];
    logic [7:0]          pidx_reg  [1:RD2];
    logic [7:0]          pval_reg  [1:RD2];

    // stage payloads
    logic signed [40:0] a_reg [2], a_next [2];
    logic signed [57:0] hi_reg [2], hi_next [2], lo_reg [2], lo_next [2];
    logic signed [57:0] qsum [2];
    logic signed [49:0] q_reg [2], q_next [2];
    logic signed [50:0] psum [2];
    logic signed [39:0] p_reg [2], p_next [2];
    logic signed [39:0] p5_reg [2], p6_reg [2], p7_reg [2], p8_reg [2], p9_reg [2];
    logic signed [40:0] sxy_reg, sxy_next;
    logic signed [60:0] fprod_reg, fprod_next;
    logic signed [41:0] cs [2];
    logic signed [25:0] c7_reg [2], c7_next [2], c8_reg [2], c9_reg [2];
    logic signed [26:0] csum_reg, csum_next;
    logic signed [45:0] unskp_reg, unskp_next;
    logic [7:0]         pa8_reg, pb8_reg, pa9_reg, pb9_reg, pa10_reg, pb10_reg;
    logic [7:0]         pa11_reg, pb11_reg, cx10_reg, cx11_reg;
    logic signed [47:0] d_reg [2], d_next [2];
    logic signed [47:0] xy_reg [3][2], xy_next [3][2];
    logic               tri_reg, tri_next;
    logic [7:0]         addr [3];
    logic [7:0]         g_reg [3];
    logic signed [17:0] xs_reg [3][2], xs_next [3][2];
    logic               inr_reg [3], inr_next [3], inr13_reg [3];
    sn2_pkg::grad_t     gr [3];
    logic signed [35:0] sqp [3][2];
    logic [31:0]        sq_reg [3][2], sq_next [3][2];
    logic signed [18:0] tx [3], ty [3];
    logic signed [18:0] dot13_reg [3], dot13_next [3], dot14_reg [3], dot15_reg [3];
    logic signed [18:0] dot16_reg [3];
    logic signed [34:0] tt [3];
    logic [31:0]        t_reg [3], t_next [3];
    logic [63:0]        tp [3];
    logic [30:0]        t2_reg [3], t2_next [3];
    logic [61:0]        t4p [3];
    logic [28:0]        t4_reg [3], t4_next [3];
    logic signed [48:0] cc_reg [3], cc_next [3];
    logic signed [50:0] sum_reg, sum_next;
    logic signed [57:0] np;
    logic signed [41:0] n_reg, n_next;
    logic signed [58:0] nh_reg, nh_next, nl_reg, nl_next, ns;
    logic signed [42:0] noise_reg, noise_next;
    logic signed [43:0] rs;

    logic [15:0] grid_in [2];
    logic [7:0]  cy_lo, cy_hi;

    // table copies
    logic [7:0] mem_lo0 [sn2_pkg::TABLE_SIZE];
    logic [7:0] mem_lo1 [sn2_pkg::TABLE_SIZE];
    logic [7:0] mem_hi0 [sn2_pkg::TABLE_SIZE];
    logic [7:0] mem_hi1 [sn2_pkg::TABLE_SIZE];
    logic [7:0] mem_hi2 [sn2_pkg::TABLE_SIZE];

    logic cfg_wr;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;

    assign grid_in[0] = s_tdata[31:16];
    assign grid_in[1] = s_tdata[47:32];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg[0] <= '0;
            offset_reg[1] <= '0;
            scale_reg[0]  <= 32'sd16777216;
            scale_reg[1]  <= 32'sd16777216;
            origin_reg[0] <= '0;
            origin_reg[1] <= '0;
            amplitude_reg <= 32'sd65536;
            overwrite_reg <= 1'b1;
        end else if (cfg_wr) begin
            unique case (sn2_pkg::reg_idx_t'(paddr[5:3]))
                sn2_pkg::REG_OFFSET_X:  offset_reg[0] <= pwdata[39:0];
                sn2_pkg::REG_OFFSET_Y:  offset_reg[1] <= pwdata[39:0];
                sn2_pkg::REG_SCALE_X:   scale_reg[0]  <= pwdata[31:0];
                sn2_pkg::REG_SCALE_Y:   scale_reg[1]  <= pwdata[31:0];
                sn2_pkg::REG_ORIGIN_X:  origin_reg[0] <= pwdata[31:0];
                sn2_pkg::REG_ORIGIN_Y:  origin_reg[1] <= pwdata[31:0];
                sn2_pkg::REG_AMPLITUDE: amplitude_reg <= pwdata[31:0];
                sn2_pkg::REG_OVERWRITE: overwrite_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (sn2_pkg::reg_idx_t'(paddr[5:3]))
            sn2_pkg::REG_OFFSET_X:  prdata = {24'b0, offset_reg[0]};
            sn2_pkg::REG_OFFSET_Y:  prdata = {24'b0, offset_reg[1]};
            sn2_pkg::REG_SCALE_X:   prdata = {32'b0, scale_reg[0]};
            sn2_pkg::REG_SCALE_Y:   prdata = {32'b0, scale_reg[1]};
            sn2_pkg::REG_ORIGIN_X:  prdata = {32'b0, origin_reg[0]};
            sn2_pkg::REG_ORIGIN_Y:  prdata = {32'b0, origin_reg[1]};
            sn2_pkg::REG_AMPLITUDE: prdata = {32'b0, amplitude_reg};
            sn2_pkg::REG_OVERWRITE: prdata = {63'b0, overwrite_reg};
            default:                prdata = '0;
        endcase
    end

    // position: (offset + (index << 16)) * scale >> 24 + origin >> 8, saturated
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            a_next[k]  = $signed({offset_reg[k][39], offset_reg[k]})
                       + $signed({{(25 - IB){1'b0}}, grid_in[k][IB-1:0], 16'b0});
            hi_next[k] = a_reg[k] * $signed(scale_reg[k][31:16]);
            lo_next[k] = a_reg[k] * $signed({1'b0, scale_reg[k][15:0]});
            qsum[k]    = hi_reg[k] + (lo_reg[k] >>> 16);
            q_next[k]  = qsum[k][57:8];
            psum[k]    = $signed({q_reg[k][49], q_reg[k]})
                       + $signed({27'b0, origin_reg[k][31:8]});
            if (psum[k][50:39] != {12{psum[k][50]}}) begin
                p_next[k] = psum[k][50] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
            end else begin
                p_next[k] = psum[k][39:0];
            end
        end
    end

    // skew, cell, unskew
    always_comb begin
        sxy_next   = p_reg[0] + p_reg[1];
        fprod_next = sxy_reg * sn2_pkg::F2_Q20;
        for (int k = 0; k < 2; k++) begin
            cs[k]      = p6_reg[k] + $signed(fprod_reg[60:20]);
            c7_next[k] = cs[k][41:16];
            d_next[k]  = p9_reg[k] - $signed({c9_reg[k], 16'b0})
                       + $signed(unskp_reg[45:4]);
        end
        csum_next  = c7_reg[0] + c7_reg[1];
        unskp_next = csum_reg * sn2_pkg::G2_Q20;
        cy_lo      = c7_reg[1][7:0];
        cy_hi      = c7_reg[1][7:0] + 8'd1;
    end

    // triangle and corner offsets
    always_comb begin
        tri_next      = d_reg[0] > d_reg[1];
        xy_next[0][0] = d_reg[0];
        xy_next[0][1] = d_reg[1];
        xy_next[1][0] = d_reg[0] - (tri_next ? sn2_pkg::ONE_Q16 : 48'sd0) + sn2_pkg::G2_Q16;
        xy_next[1][1] = d_reg[1] - (tri_next ? 48'sd0 : sn2_pkg::ONE_Q16) + sn2_pkg::G2_Q16;
        xy_next[2][0] = d_reg[0] - sn2_pkg::ONE_Q16 + sn2_pkg::G2_Q16 + sn2_pkg::G2_Q16;
        xy_next[2][1] = d_reg[1] - sn2_pkg::ONE_Q16 + sn2_pkg::G2_Q16 + sn2_pkg::G2_Q16;
        addr[0] = cx11_reg + pa11_reg;
        addr[1] = tri_reg ? cx11_reg + 8'd1 + pa11_reg : cx11_reg + pb11_reg;
        addr[2] = cx11_reg + 8'd1 + pb11_reg;
        for (int c = 0; c < 3; c++) begin
            inr_next[c] = (xy_reg[c][0] > -sn2_pkg::ONE_Q16) && (xy_reg[c][0] < sn2_pkg::ONE_Q16)
                       && (xy_reg[c][1] > -sn2_pkg::ONE_Q16) && (xy_reg[c][1] < sn2_pkg::ONE_Q16);
            xs_next[c][0] = xy_reg[c][0][17:0];
            xs_next[c][1] = xy_reg[c][1][17:0];
        end
    end

    // falloff and contributions
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            gr[c] = sn2_pkg::grad_of(g_reg[c]);
            for (int k = 0; k < 2; k++) begin
                sqp[c][k]     = xs_reg[c][k] * xs_reg[c][k];
                sq_next[c][k] = sqp[c][k][31:0];
            end
            tx[c] = gr[c].x_pos ? 19'(xs_reg[c][0])
                  : (gr[c].x_neg ? -19'(xs_reg[c][0]) : 19'sd0);
            ty[c] = gr[c].y_pos ? 19'(xs_reg[c][1])
                  : (gr[c].y_neg ? -19'(xs_reg[c][1]) : 19'sd0);
            dot13_next[c] = tx[c] + ty[c];
            tt[c] = sn2_pkg::HALF_Q32 - $signed({3'b0, sq_reg[c][0]})
                  - $signed({3'b0, sq_reg[c][1]});
            t_next[c]  = (inr13_reg[c] && tt[c] > 35'sd0) ? tt[c][31:0] : 32'd0;
            tp[c]      = {32'b0, t_reg[c]} * {32'b0, t_reg[c]};
            t2_next[c] = tp[c][62:32];
            t4p[c]     = {31'b0, t2_reg[c]} * {31'b0, t2_reg[c]};
            t4_next[c] = t4p[c][60:32];
            cc_next[c] = $signed({1'b0, t4_reg[c]}) * dot16_reg[c];
        end
        sum_next = cc_reg[0] + cc_reg[1] + cc_reg[2];
    end

    // gain, amplitude, merge, saturate
    always_comb begin
        np         = sum_reg * sn2_pkg::GAIN_70;
        n_next     = np[57:16];
        nh_next    = n_reg * $signed(amplitude_reg[31:16]);
        nl_next    = n_reg * $signed({1'b0, amplitude_reg[15:0]});
        ns         = nh_reg + (nl_reg >>> 16);
        noise_next = ns[58:16];
        rs         = overwrite_reg ? 44'(noise_reg) : 44'(noise_reg) + 44'(prior_reg[NS]);
        if (rs[43:31] != {13{rs[43]}}) begin
            res_next = rs[43] ? 32'h8000_0000 : 32'h7fff_ffff;
        end else begin
            res_next = rs[31:0];
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 1; k <= NS; k++) begin
                v_reg[k] <= 1'b0;
            end
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            v_reg[1] <= s_tvalid;
            for (int k = 2; k <= NS; k++) begin
                v_reg[k] <= v_reg[k-1];
            end
            m_tvalid_reg <= v_reg[NS] && (op_reg[NS] == sn2_pkg::OP_SAMPLE);
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en) begin
            op_reg[1]    <= s_tuser;
            prior_reg[1] <= s_tdata[79:48];
            pidx_reg[1]  <= s_tdata[7:0];
            pval_reg[1]  <= s_tdata[15:8];
            for (int k = 2; k <= NS; k++) begin
                op_reg[k]    <= op_reg[k-1];
                prior_reg[k] <= prior_reg[k-1];
            end
            for (int k = 2; k <= RD2; k++) begin
                pidx_reg[k] <= pidx_reg[k-1];
                pval_reg[k] <= pval_reg[k-1];
            end
            for (int k = 0; k < 2; k++) begin
                a_reg[k]  <= a_next[k];
                hi_reg[k] <= hi_next[k];
                lo_reg[k] <= lo_next[k];
                q_reg[k]  <= q_next[k];
                p_reg[k]  <= p_next[k];
                p5_reg[k] <= p_reg[k];
                p6_reg[k] <= p5_reg[k];
                p7_reg[k] <= p6_reg[k];
                p8_reg[k] <= p7_reg[k];
                p9_reg[k] <= p8_reg[k];
                c7_reg[k] <= c7_next[k];
                c8_reg[k] <= c7_reg[k];
                c9_reg[k] <= c8_reg[k];
                d_reg[k]  <= d_next[k];
            end
            sxy_reg   <= sxy_next;
            fprod_reg <= fprod_next;
            csum_reg  <= csum_next;
            unskp_reg <= unskp_next;
            pa9_reg   <= pa8_reg;
            pb9_reg   <= pb8_reg;
            pa10_reg  <= pa9_reg;
            pb10_reg  <= pb9_reg;
            pa11_reg  <= pa10_reg;
            pb11_reg  <= pb10_reg;
            cx10_reg  <= c9_reg[0][7:0];
            cx11_reg  <= cx10_reg;
            tri_reg   <= tri_next;
            for (int c = 0; c < 3; c++) begin
                xy_reg[c][0]  <= xy_next[c][0];
                xy_reg[c][1]  <= xy_next[c][1];
                xs_reg[c][0]  <= xs_next[c][0];
                xs_reg[c][1]  <= xs_next[c][1];
                inr_reg[c]    <= inr_next[c];
                inr13_reg[c]  <= inr_reg[c];
                sq_reg[c][0]  <= sq_next[c][0];
                sq_reg[c][1]  <= sq_next[c][1];
                dot13_reg[c]  <= dot13_next[c];
                dot14_reg[c]  <= dot13_reg[c];
                dot15_reg[c]  <= dot14_reg[c];
                dot16_reg[c]  <= dot15_reg[c];
                t_reg[c]      <= t_next[c];
                t2_reg[c]     <= t2_next[c];
                t4_reg[c]     <= t4_next[c];
                cc_reg[c]     <= cc_next[c];
            end
            sum_reg     <= sum_next;
            n_reg       <= n_next;
            nh_reg      <= nh_next;
            nl_reg      <= nl_next;
            noise_reg   <= noise_next;
            m_tdata_reg <= res_next;
        end
    end

    // first-level table copies: loads write where samples read the row entries
    always_ff @(posedge aclk) begin
        if (en) begin
            if (v_reg[RD1] && (op_reg[RD1] == sn2_pkg::OP_LOAD)) begin
                mem_lo0[pidx_reg[RD1]] <= pval_reg[RD1];
                mem_lo1[pidx_reg[RD1]] <= pval_reg[RD1];
            end
            pa8_reg <= mem_lo0[cy_lo];
            pb8_reg <= mem_lo1[cy_hi];
        end
    end

    // second-level table copies: one per corner
    always_ff @(posedge aclk) begin
        if (en) begin
            if (v_reg[RD2] && (op_reg[RD2] == sn2_pkg::OP_LOAD)) begin
                mem_hi0[pidx_reg[RD2]] <= pval_reg[RD2];
                mem_hi1[pidx_reg[RD2]] <= pval_reg[RD2];
                mem_hi2[pidx_reg[RD2]] <= pval_reg[RD2];
            end
            g_reg[0] <= mem_hi0[addr[0]];
            g_reg[1] <= mem_hi1[addr[1]];
            g_reg[2] <= mem_hi2[addr[2]];
        end
    end

endmodule
`default_nettype wire

/* verif/tb_simplex_noise_2d_grid.sv */
// Self-checking testbench for the 2D simplex noise grid block: streamed loads and samples.
`default_nettype none
module tb_simplex_noise_2d_grid;

    typedef logic signed [127:0] wide_t;

    class noise_scoreboard;
        logic [7:0]  perm [sn2_pkg::TABLE_SIZE];
        longint      off_x, off_y, scl_x, scl_y, org_x, org_y, amp;
        bit          overwrite;
        logic [31:0] pending [$];

        function new();
            off_x = 0; off_y = 0; scl_x = 16777216; scl_y = 16777216;
            org_x = 0; org_y = 0; amp = 65536; overwrite = 1;
        endfunction

        function void set_reg(sn2_pkg::reg_idx_t idx, logic [63:0] v);
            case (idx)
                sn2_pkg::REG_OFFSET_X:  off_x = longint'(signed'(v[39:0]));
                sn2_pkg::REG_OFFSET_Y:  off_y = longint'(signed'(v[39:0]));
                sn2_pkg::REG_SCALE_X:   scl_x = longint'(signed'(v[31:0]));
                sn2_pkg::REG_SCALE_Y:   scl_y = longint'(signed'(v[31:0]));
                sn2_pkg::REG_ORIGIN_X:  org_x = longint'({32'b0, v[31:0]});
                sn2_pkg::REG_ORIGIN_Y:  org_y = longint'({32'b0, v[31:0]});
                sn2_pkg::REG_AMPLITUDE: amp   = longint'(signed'(v[31:0]));
                sn2_pkg::REG_OVERWRITE: overwrite = v[0];
                default: ;
            endcase
        endfunction

        function wide_t clamp(wide_t v, wide_t lo, wide_t hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function wide_t grid_pos(logic [15:0] g, longint off, longint sc, longint org);
            wide_t a;
            a = wide_t'(off) + (wide_t'({112'b0, g}) <<< 16);
            return clamp(((a * wide_t'(sc)) >>> 24) + (wide_t'(org) >>> 8),
                         -(wide_t'(1) <<< 39), (wide_t'(1) <<< 39) - 1);
        endfunction

        function logic [7:0] lookup(wide_t i);
            return perm[i[7:0]];
        endfunction

        function wide_t falloff(wide_t x, wide_t y, logic [7:0] g);
            wide_t t, t2, t4, dot;
            int m;
            if (x <= -65536 || x >= 65536 || y <= -65536 || y >= 65536) return 0;
            t = (wide_t'(1) <<< 31) - x * x - y * y;
            if (t <= 0) return 0;
            t2 = (t * t) >>> 32;
            t4 = (t2 * t2) >>> 32;
            m = g % 12;
            if (m < 8) dot = (m[0] ? -x : x) + (m[2] ? 0 : (m[1] ? -y : y));
            else dot = m[0] ? -y : y;
            return t4 * dot;
        endfunction

        function void note(logic op, logic [79:0] d);
            wide_t px, py, skew, cx, cy, unsk, x0, y0, i, j, sum, n32, res;
            logic [7:0] g0, g1, g2;
            if (op == sn2_pkg::OP_LOAD) begin
                perm[d[7:0]] = d[15:8];
                return;
            end
            px = grid_pos(d[31:16], off_x, scl_x, org_x);
            py = grid_pos(d[47:32], off_y, scl_y, org_y);
            skew = ((px + py) * 383805) >>> 20;
            cx = (px + skew) >>> 16;
            cy = (py + skew) >>> 16;
            unsk = ((cx + cy) * 221590) >>> 4;
            x0 = px - cx * 65536 + unsk;
            y0 = py - cy * 65536 + unsk;
            if (x0 > y0) begin i = 1; j = 0; end else begin i = 0; j = 1; end
            g0 = lookup(cx + lookup(cy));
            g1 = lookup(cx + i + lookup(cy + j));
            g2 = lookup(cx + 1 + lookup(cy + 1));
            sum = falloff(x0, y0, g0)
                + falloff(x0 - i * 65536 + 13849, y0 - j * 65536 + 13849, g1)
                + falloff(x0 - 65536 + 2 * 13849, y0 - 65536 + 2 * 13849, g2);
            n32 = (sum * 70) >>> 16;
            res = (n32 * wide_t'(amp)) >>> 32;
            if (!overwrite) res = res + wide_t'(signed'(d[79:48]));
            res = clamp(res, -(wide_t'(1) <<< 31), (wide_t'(1) <<< 31) - 1);
            pending.push_back(res[31:0]);
        endfunction

        // 0 ok, 1 unexpected, 2 wrong value
        function int check(logic [31:0] got, output logic [31:0] want);
            want = 'x;
            if (pending.size() == 0) return 1;
            want = pending.pop_front();
            return (got === want) ? 0 : 2;
        endfunction
    endclass

    logic        aclk = 0, aresetn = 0;
    logic        s_tvalid = 0, s_tuser = 0, m_tready = 0;
    logic [79:0] s_tdata = '0;
    logic        s_tready, m_tvalid, pready;
    logic [31:0] m_tdata;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0, prdata;

    noise_scoreboard sb = new();
    int errors = 0, idle_cycles = 0, burst_left = 0, stall_mode = 0;
    bit no_gaps = 0;

    simplex_noise_2d_grid uut (.*);

    initial forever #5 aclk = ~aclk;

    task report_mismatch(string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        errors++;
    endtask

    always @(posedge aclk) begin
        logic [31:0] want;
        int st;
        if (aresetn && m_tvalid && m_tready) begin
            st = sb.check(m_tdata, want);
            if (st == 1) report_mismatch($sformatf("unexpected noise_value %h", m_tdata));
            else if (st == 2)
                report_mismatch($sformatf("noise_value %h, expected %h", m_tdata, want));
        end
    end

    always @(posedge aclk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000) begin
            $display("tb_simplex_noise_2d_grid: errors");
            $finish;
        end
    end

    task send(logic op, logic [79:0] d);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if (!no_gaps) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note(op, d);
        burst_left--;
    endtask

    task load(logic [7:0] idx, logic [7:0] v);
        send(sn2_pkg::OP_LOAD, {$urandom(), $urandom(), v, idx});
    endtask

    task sample(logic [15:0] gx, logic [15:0] gy, logic [31:0] prior);
        send(sn2_pkg::OP_SAMPLE, {prior, gy, gx, 16'($urandom_range(0, 65535))});
    endtask

    task drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task write_reg(sn2_pkg::reg_idx_t idx, logic [63:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 3'b000}; pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        sb.set_reg(idx, v);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task configure(logic [63:0] ox, logic [63:0] oy, logic [63:0] sx, logic [63:0] sy,
                   logic [63:0] gx, logic [63:0] gy, logic [63:0] a, logic [63:0] ow);
        write_reg(sn2_pkg::REG_OFFSET_X, ox);
        write_reg(sn2_pkg::REG_OFFSET_Y, oy);
        write_reg(sn2_pkg::REG_SCALE_X, sx);
        write_reg(sn2_pkg::REG_SCALE_Y, sy);
        write_reg(sn2_pkg::REG_ORIGIN_X, gx);
        write_reg(sn2_pkg::REG_ORIGIN_Y, gy);
        write_reg(sn2_pkg::REG_AMPLITUDE, a);
        write_reg(sn2_pkg::REG_OVERWRITE, ow);
    endtask

    function logic [31:0] rand_prior();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 131072) - 65536;
            default: return $urandom();
        endcase
    endfunction

    function logic [15:0] rand_grid();
        return $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 63)) : 16'($urandom());
    endfunction

    task random_items(int n);
        repeat (n) begin
            if ($urandom_range(0, 9) == 0) load(8'($urandom()), 8'($urandom()));
            else sample(rand_grid(), rand_grid(), rand_prior());
        end
        drain();
    endtask

    initial begin
        logic [63:0] r40;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // whole table first so no sample reads an unwritten entry
        no_gaps = 1;
        for (int k = 0; k < sn2_pkg::TABLE_SIZE; k++) load(8'(k), 8'($urandom()));
        load(8'hff, 8'hff);
        load(8'h00, 8'h00);
        no_gaps = 0;

        sample(16'h0000, 16'h0000, 32'h00000000);
        sample(16'hffff, 16'hffff, 32'h7fffffff);
        sample(16'hffff, 16'h0000, 32'h80000000);
        sample(16'h0000, 16'hffff, 32'hffffffff);
        sample(16'h0003, 16'h0001, 32'h00010000);
        sample(16'h0001, 16'h0003, 32'h12345678);
        drain();

        // add mode near the rails, large gain
        configure(64'h0000008000, 64'hffffff8000, 64'h00400000, 64'h00200000,
                  64'h37000000, 64'h91000000, 64'h7fffffff, 64'h0);
        sample(16'h0000, 16'h0000, 32'h7fffffff);
        sample(16'h0005, 16'h0007, 32'h80000000);
        sample(16'hffff, 16'h1234, 32'h7fff0000);
        sample(16'h00aa, 16'h0055, 32'h80010000);
        random_items(220);

        // position saturation at the top of the range
        configure(64'h7fffffffff, 64'h7fffffffff, 64'h7fffffff, 64'h7fffffff,
                  64'hffffffff, 64'hffffffff, 64'h80000000, 64'h1);
        random_items(150);

        configure(64'h8000000000, 64'h8000000000, 64'h80000000, 64'h80000000,
                  64'h0, 64'h0, 64'h7fffffff, 64'h0);
        random_items(150);

        configure(64'h0, 64'h0, 64'h01000000, 64'h01000000,
                  64'h0, 64'h0, 64'h00010000, 64'h1);
        no_gaps = 1;
        random_items(200);
        no_gaps = 0;

        repeat (5) begin
            r40 = {$urandom(), $urandom()};
            configure({24'b0, r40[39:0]} >> $urandom_range(0, 20), $urandom(),
                      $urandom() >> $urandom_range(0, 8), $urandom(),
                      $urandom(), $urandom(), $urandom(), $urandom_range(0, 1));
            random_items(190);
        end

        if (errors == 0) $display("tb_simplex_noise_2d_grid: clean");
        else $display("tb_simplex_noise_2d_grid: errors");
        $finish;
    end
endmodule
`default_nettype wire
